### rtl/fwo_pkg.sv
`timescale 1ns / 1ps
package fwo_pkg;

   localparam int WHEELS = 4;
   // The window length must be a power of two: the average is taken by a shift.
   localparam int WINDOW = 8;
   localparam int WIN_SH = $clog2(WINDOW);
   localparam int POS_W = (WIN_SH < 1) ? 1 : WIN_SH;
   localparam logic [31:0] AUTO_ZERO_MS = 32'd3500;

   localparam logic [2:0] REG_MM_FR = 3'd0;
   localparam logic [2:0] REG_MM_RR = 3'd1;
   localparam logic [2:0] REG_MM_FL = 3'd2;
   localparam logic [2:0] REG_MM_RL = 3'd3;
   localparam logic [2:0] REG_TPS = 3'd4;
   localparam logic [2:0] REG_OLD_W = 3'd5;
   localparam logic [2:0] REG_NEW_W = 3'd6;
   localparam logic [2:0] REG_HEAD = 3'd7;

   typedef struct packed {
      logic signed [31:0] count_front_right;
      logic signed [31:0] count_rear_right;
      logic signed [31:0] count_front_left;
      logic signed [31:0] count_rear_left;
      logic zero_request;
      logic inertial_online;
      logic imu_locked;
      logic [31:0] elapsed_ms;
   } req_type;

   typedef struct packed {
      logic [1:0] wheel_id;
      logic last_wheel;
      logic signed [15:0] raw_speed;
      logic signed [15:0] avg_speed;
      logic signed [15:0] display_speed;
      logic signed [31:0] wheel_distance;
      logic signed [15:0] left_speed;
      logic signed [15:0] right_speed;
      logic signed [31:0] left_distance;
      logic signed [31:0] right_distance;
      logic signed [31:0] chassis_distance;
      logic signed [15:0] encoder_heading;
   } rsp_type;

   typedef struct packed {
      logic [3:0][23:0] mm_per_count;
      logic [13:0] ticks_per_second;
      logic [16:0] filter_old_weight;
      logic [16:0] filter_new_weight;
      logic [23:0] heading_per_mm;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DELTA, ST_SPEED, ST_ROUND, ST_FMUL, ST_FILT,
      ST_ZERO, ST_SUMS, ST_HEAD, ST_OUT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_DELTA, OP_SPEED, OP_ROUND, OP_FMUL, OP_FILT,
      OP_ZERO, OP_SUMS, OP_HEAD
   } op_type;

   typedef struct packed {
      op_type op;
      logic [1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic primed;
   } status_type;

   // Division by 2^k, rounding half away from zero.
   function automatic logic signed [63:0] div_round_pow2(input logic signed [63:0] x,
                                                         input int k);
      logic [63:0] mag;
      logic [63:0] q;
      mag = x[63] ? 64'(-x) : 64'(x);
      q = (mag + (64'd1 << (k - 1))) >> k;
      return x[63] ? -$signed(q) : $signed(q);
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [63:0] x);
      if (x > 64'sd32767) return 16'sh7fff;
      if (x < -64'sd32768) return 16'sh8000;
      return x[15:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      if (x > 64'sd2147483647) return 32'sh7fffffff;
      if (x < -64'sd2147483648) return 32'sh80000000;
      return x[31:0];
   endfunction

   function automatic logic signed [47:0] clamp46(input logic signed [63:0] x);
      if (x > (64'sd1 <<< 46)) return 48'sd1 <<< 46;
      if (x < -(64'sd1 <<< 46)) return -(48'sd1 <<< 46);
      return x[47:0];
   endfunction

endpackage

### rtl/fwo_ctrl.sv
`timescale 1ns / 1ps
module fwo_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   output logic rsp_valid,
   input  logic rsp_stall,
   input  fwo_pkg::status_type status,
   output fwo_pkg::cmd_type cmd
);
   import fwo_pkg::*;

   state_type state_ff, state_in;
   logic [1:0] idx_ff, idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      cmd.op = OP_NONE;
      cmd.idx = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            idx_in = 2'd0;
            if (req_valid) begin
               cmd.op = OP_LOAD;
               state_in = status.primed ? ST_DELTA : ST_ZERO;
            end
         end
         ST_DELTA: begin
            cmd.op = OP_DELTA;
            state_in = ST_SPEED;
         end
         ST_SPEED: begin
            cmd.op = OP_SPEED;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.op = OP_ROUND;
            state_in = ST_FMUL;
         end
         ST_FMUL: begin
            cmd.op = OP_FMUL;
            state_in = ST_FILT;
         end
         ST_FILT: begin
            cmd.op = OP_FILT;
            idx_in = idx_ff + 2'd1;
            state_in = (idx_ff == 2'd3) ? ST_ZERO : ST_DELTA;
         end
         ST_ZERO: begin
            cmd.op = OP_ZERO;
            state_in = ST_SUMS;
         end
         ST_SUMS: begin
            cmd.op = OP_SUMS;
            state_in = ST_HEAD;
         end
         ST_HEAD: begin
            cmd.op = OP_HEAD;
            idx_in = 2'd0;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd3) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

### rtl/fwo_datapath.sv
`timescale 1ns / 1ps
module fwo_datapath (
   input  logic clock,
   input  logic reset,
   input  fwo_pkg::cmd_type cmd,
   output fwo_pkg::status_type status,
   input  fwo_pkg::cfg_type cfg,
   input  fwo_pkg::req_type req_data,
   output fwo_pkg::rsp_type rsp_data
);
   import fwo_pkg::*;

   req_type in_ff;
   logic [31:0] prev_ff [WHEELS];
   logic [31:0] sum_ff [WHEELS];
   logic [31:0] win_ff [WHEELS][WINDOW];
   logic [POS_W-1:0] pos_ff;
   logic signed [15:0] filt_ff [WHEELS];
   logic signed [31:0] dist_ff [WHEELS];
   logic signed [15:0] raw_ff [WHEELS];
   logic signed [15:0] avg_ff [WHEELS];
   logic primed_ff, azp_ff;

   logic signed [56:0] q_ff, s_ff;
   logic signed [62:0] rp_ff, ap_ff;
   logic signed [31:0] inc_ff;
   logic signed [33:0] fo_ff, fn_ff;
   logic signed [15:0] lspd_ff, rspd_ff, head_ff;
   logic signed [31:0] ldist_ff, rdist_ff, chassis_ff;
   logic signed [57:0] hprod_ff;

   logic [31:0] cnt, d, ns;
   logic [31:0] counts [WHEELS];
   logic [23:0] m;
   logic zero_now;
   logic [POS_W:0] pos_next;

   assign counts[0] = in_ff.count_front_right;
   assign counts[1] = in_ff.count_rear_right;
   assign counts[2] = in_ff.count_front_left;
   assign counts[3] = in_ff.count_rear_left;
   assign cnt = counts[cmd.idx];
   assign m = cfg.mm_per_count[cmd.idx];
   assign d = cnt - prev_ff[cmd.idx];
   assign ns = sum_ff[cmd.idx] - win_ff[cmd.idx][pos_ff] + d;
   assign pos_next = {1'b0, pos_ff} + 1'b1;
   assign zero_now = in_ff.zero_request |
      (azp_ff & in_ff.inertial_online & in_ff.imu_locked &
       (in_ff.elapsed_ms >= AUTO_ZERO_MS));
   assign status.primed = primed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff <= 1'b0;
         azp_ff <= 1'b1;
         pos_ff <= '0;
         for (int w = 0; w < WHEELS; w++) begin
            prev_ff[w] <= '0;
            sum_ff[w] <= '0;
            filt_ff[w] <= '0;
            dist_ff[w] <= '0;
            raw_ff[w] <= '0;
            avg_ff[w] <= '0;
            for (int j = 0; j < WINDOW; j++) win_ff[w][j] <= '0;
         end
      end else begin
         case (cmd.op)
            OP_LOAD: in_ff <= req_data;
            OP_DELTA: begin
               prev_ff[cmd.idx] <= cnt;
               sum_ff[cmd.idx] <= ns;
               win_ff[cmd.idx][pos_ff] <= d;
               q_ff <= $signed(d) * $signed({1'b0, m});
               s_ff <= $signed(ns) * $signed({1'b0, m});
            end
            OP_SPEED: begin
               rp_ff <= clamp46(64'(q_ff)) * $signed({1'b0, cfg.ticks_per_second});
               ap_ff <= clamp46(64'(s_ff)) * $signed({1'b0, cfg.ticks_per_second});
               inc_ff <= sat32(div_round_pow2(64'(q_ff), 16));
            end
            OP_ROUND: begin
               raw_ff[cmd.idx] <= sat16(div_round_pow2(64'(rp_ff), 16));
               avg_ff[cmd.idx] <= sat16(div_round_pow2(64'(ap_ff), 16 + WIN_SH));
               dist_ff[cmd.idx] <= sat32(64'(dist_ff[cmd.idx]) + 64'(inc_ff));
            end
            OP_FMUL: begin
               fo_ff <= filt_ff[cmd.idx] * $signed({1'b0, cfg.filter_old_weight});
               fn_ff <= avg_ff[cmd.idx] * $signed({1'b0, cfg.filter_new_weight});
            end
            OP_FILT: filt_ff[cmd.idx] <= sat16(div_round_pow2(64'(fo_ff) + 64'(fn_ff), 16));
            OP_ZERO: begin
               primed_ff <= 1'b1;
               if (zero_now) azp_ff <= 1'b0;
               // Priming and zeroing both restart the odometry from this transfer's counts.
               if (!primed_ff || zero_now) begin
                  pos_ff <= '0;
                  for (int w = 0; w < WHEELS; w++) begin
                     prev_ff[w] <= counts[w];
                     sum_ff[w] <= '0;
                     filt_ff[w] <= '0;
                     dist_ff[w] <= '0;
                     raw_ff[w] <= '0;
                     avg_ff[w] <= '0;
                     for (int j = 0; j < WINDOW; j++) win_ff[w][j] <= '0;
                  end
               end else begin
                  pos_ff <= (pos_next >= (POS_W + 1)'(WINDOW)) ? '0 : pos_next[POS_W-1:0];
               end
            end
            OP_SUMS: begin
               rspd_ff <= 16'(div_round_pow2(64'(avg_ff[0]) + 64'(avg_ff[1]), 1));
               lspd_ff <= 16'(div_round_pow2(64'(avg_ff[2]) + 64'(avg_ff[3]), 1));
               rdist_ff <= sat32(div_round_pow2(64'(dist_ff[0]) + 64'(dist_ff[1]), 1));
               ldist_ff <= sat32(div_round_pow2(64'(dist_ff[2]) + 64'(dist_ff[3]), 1));
               chassis_ff <= sat32(div_round_pow2(64'(dist_ff[0]) + 64'(dist_ff[1])
                                                  + 64'(dist_ff[2]) + 64'(dist_ff[3]), 2));
               hprod_ff <= (34'(dist_ff[0]) + 34'(dist_ff[1]) - 34'(dist_ff[2])
                            - 34'(dist_ff[3])) * $signed({1'b0, cfg.heading_per_mm});
            end
            OP_HEAD: head_ff <= sat16(div_round_pow2(64'(hprod_ff), 17));
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_data.wheel_id = cmd.idx;
      rsp_data.last_wheel = (cmd.idx == 2'd3);
      rsp_data.raw_speed = raw_ff[cmd.idx];
      rsp_data.avg_speed = avg_ff[cmd.idx];
      rsp_data.display_speed = filt_ff[cmd.idx];
      rsp_data.wheel_distance = dist_ff[cmd.idx];
      rsp_data.left_speed = lspd_ff;
      rsp_data.right_speed = rspd_ff;
      rsp_data.left_distance = ldist_ff;
      rsp_data.right_distance = rdist_ff;
      rsp_data.chassis_distance = chassis_ff;
      rsp_data.encoder_heading = head_ff;
   end

endmodule

### rtl/four_wheel_odometry.sv
`timescale 1ns / 1ps
// Four-wheel odometry. Each request transfer carries one control tick's four encoder
// counts and yields four response transfers, front right, rear right, front left and
// rear left in that order, the last flagged. One shared sequencer works the wheels in
// turn, five steps per wheel (delta, speed, round, filter multiply, filter), then
// three steps for zeroing and the side and heading figures, and then gives one
// response per cycle while rsp_stall is low. No new request is taken until all four
// responses have gone. The first tick after reset only primes the stored counts and
// reports zeros; it skips the wheel passes.
module four_wheel_odometry (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  fwo_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output fwo_pkg::rsp_type rsp_data,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [4:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   import fwo_pkg::*;

   cfg_type cfg_ff;
   cmd_type cmd;
   status_type status;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mm_per_count <= {4{24'd65536}};
         cfg_ff.ticks_per_second <= 14'd100;
         cfg_ff.filter_old_weight <= 17'd49152;
         cfg_ff.filter_new_weight <= 17'd16384;
         cfg_ff.heading_per_mm <= 24'd65536;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (reg_idx)
            REG_MM_FR: cfg_ff.mm_per_count[0] <= csr_pwdata[23:0];
            REG_MM_RR: cfg_ff.mm_per_count[1] <= csr_pwdata[23:0];
            REG_MM_FL: cfg_ff.mm_per_count[2] <= csr_pwdata[23:0];
            REG_MM_RL: cfg_ff.mm_per_count[3] <= csr_pwdata[23:0];
            REG_TPS: cfg_ff.ticks_per_second <= csr_pwdata[13:0];
            REG_OLD_W: cfg_ff.filter_old_weight <= csr_pwdata[16:0];
            REG_NEW_W: cfg_ff.filter_new_weight <= csr_pwdata[16:0];
            REG_HEAD: cfg_ff.heading_per_mm <= csr_pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_MM_FR: csr_prdata = 32'(cfg_ff.mm_per_count[0]);
         REG_MM_RR: csr_prdata = 32'(cfg_ff.mm_per_count[1]);
         REG_MM_FL: csr_prdata = 32'(cfg_ff.mm_per_count[2]);
         REG_MM_RL: csr_prdata = 32'(cfg_ff.mm_per_count[3]);
         REG_TPS: csr_prdata = 32'(cfg_ff.ticks_per_second);
         REG_OLD_W: csr_prdata = 32'(cfg_ff.filter_old_weight);
         REG_NEW_W: csr_prdata = 32'(cfg_ff.filter_new_weight);
         REG_HEAD: csr_prdata = 32'(cfg_ff.heading_per_mm);
         default: csr_prdata = '0;
      endcase
   end

   fwo_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .status(status),
      .cmd(cmd)
   );

   fwo_datapath u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .cfg(cfg_ff),
      .req_data(req_data),
      .rsp_data(rsp_data)
   );

endmodule
